// ===== rtl/tssp_pkg.sv =====
package tssp_pkg;

  localparam int ElapsedWidth = 20;
  localparam int SquirtWidth  = 17;
  localparam int TimeWidth    = 16;
  localparam int LevelWidth   = 8;
  localparam int CfgIdxWidth  = 3;
  localparam int CfgDataWidth = 16;

  localparam logic [ElapsedWidth-1:0] ELAPSED_MAX = '1;

  localparam logic [LevelWidth-1:0] DRIVE_LEVEL_RST  = 8'd150;
  localparam logic [TimeWidth-1:0]  SETTLE_WAIT_RST  = 16'd1000;
  localparam logic [TimeWidth-1:0]  REFILL_TIME_RST  = 16'd1000;
  localparam logic [TimeWidth-1:0]  DRIP_WAIT_RST    = 16'd2000;
  localparam logic [TimeWidth-1:0]  SHORT_DRIP_RST   = 16'd10;
  localparam logic [TimeWidth-1:0]  SHORT_DRIP_QTY   = 16'd1;

  typedef enum logic [1:0] {
    ACT_TICK     = 2'd0,
    ACT_DISPENSE = 2'd1,
    ACT_STOP     = 2'd2
  } action_t;

  typedef enum logic [2:0] {
    PH_READY  = 3'd0,
    PH_SQUIRT = 3'd1,
    PH_SETTLE = 3'd2,
    PH_SUCK   = 3'd3,
    PH_DRIP   = 3'd4
  } phase_t;

  typedef enum logic [CfgIdxWidth-1:0] {
    CFG_DRIVE_LEVEL = 3'd0,
    CFG_SETTLE_WAIT = 3'd1,
    CFG_REFILL_TIME = 3'd2,
    CFG_DRIP_WAIT   = 3'd3,
    CFG_SHORT_DRIP  = 3'd4
  } cfg_idx_t;

  typedef struct packed {
    logic [LevelWidth-1:0] drive_level;
    logic [TimeWidth-1:0]  settle_wait_ms;
    logic [TimeWidth-1:0]  refill_time_ms;
    logic [TimeWidth-1:0]  drip_wait_ms;
    logic [TimeWidth-1:0]  short_drip_ms;
  } cfg_t;

  typedef struct packed {
    logic                  accepted;
    logic                  busy_res;
    logic [2:0]            phase;
    logic [LevelWidth-1:0] squirt_drive;
    logic [LevelWidth-1:0] suck_drive;
  } res_t;

endpackage

// ===== rtl/tssp_if.sv =====
interface tssp_in_if
  import tssp_pkg::*;
();
  logic                 valid;
  logic                 ready;
  logic [1:0]           action;
  logic [TimeWidth-1:0] quantity;

  modport source (output valid, output action, output quantity, input ready);
  modport sink   (input valid, input action, input quantity, output ready);
endinterface

interface tssp_out_if
  import tssp_pkg::*;
();
  logic                  valid;
  logic                  ready;
  logic                  accepted;
  logic                  busy_res;
  logic [2:0]            phase;
  logic [LevelWidth-1:0] squirt_drive;
  logic [LevelWidth-1:0] suck_drive;

  modport source (output valid, output accepted, output busy_res, output phase,
                  output squirt_drive, output suck_drive, input ready);
  modport sink   (input valid, input accepted, input busy_res, input phase,
                  input squirt_drive, input suck_drive, output ready);
endinterface

// ===== rtl/tssp_cfg.sv =====
module tssp_cfg
  import tssp_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    cfg_we,
  input  logic [CfgIdxWidth-1:0]  cfg_idx,
  input  logic [CfgDataWidth-1:0] cfg_wdata,
  output cfg_t                    cfg
);

  cfg_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.drive_level    <= DRIVE_LEVEL_RST;
      cfg_r.settle_wait_ms <= SETTLE_WAIT_RST;
      cfg_r.refill_time_ms <= REFILL_TIME_RST;
      cfg_r.drip_wait_ms   <= DRIP_WAIT_RST;
      cfg_r.short_drip_ms  <= SHORT_DRIP_RST;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        CFG_DRIVE_LEVEL: cfg_r.drive_level    <= cfg_wdata[LevelWidth-1:0];
        CFG_SETTLE_WAIT: cfg_r.settle_wait_ms <= cfg_wdata[TimeWidth-1:0];
        CFG_REFILL_TIME: cfg_r.refill_time_ms <= cfg_wdata[TimeWidth-1:0];
        CFG_DRIP_WAIT:   cfg_r.drip_wait_ms   <= cfg_wdata[TimeWidth-1:0];
        CFG_SHORT_DRIP:  cfg_r.short_drip_ms  <= cfg_wdata[TimeWidth-1:0];
        default: ;
      endcase
    end
  end

  assign cfg = cfg_r;

endmodule

// ===== rtl/tssp_core.sv =====
module tssp_core
  import tssp_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 fire,
  input  logic [1:0]           action,
  input  logic [TimeWidth-1:0] quantity,
  input  cfg_t                 cfg,
  output res_t                 res
);

  phase_t                  phase_r, phase_nxt;
  logic [ElapsedWidth-1:0] elapsed_r, elapsed_nxt;
  logic [SquirtWidth-1:0]  squirt_ticks_r, squirt_ticks_nxt;
  logic [TimeWidth-1:0]    drip_ticks_r, drip_ticks_nxt;
  logic [LevelWidth-1:0]   squirt_lvl_r, squirt_lvl_nxt;
  logic [LevelWidth-1:0]   suck_lvl_r, suck_lvl_nxt;

  logic                    busy;
  logic                    is_tick, is_dispense, is_stop;
  logic                    start;
  logic [ElapsedWidth-1:0] elapsed_inc;
  logic [ElapsedWidth-1:0] t1, t2, t3, t4, thresh;
  logic                    phase_done;

  assign busy        = (phase_r != PH_READY);
  assign is_tick     = (action == ACT_TICK);
  assign is_dispense = (action == ACT_DISPENSE);
  assign is_stop     = (action == ACT_STOP);
  assign start       = is_dispense && !busy;

  assign elapsed_inc = (elapsed_r == ELAPSED_MAX) ? elapsed_r
                                                  : elapsed_r + ElapsedWidth'(1);

  // Phase boundaries are cumulative from the start of the squirt.
  assign t1 = ElapsedWidth'(squirt_ticks_r);
  assign t2 = t1 + ElapsedWidth'(cfg.settle_wait_ms);
  assign t3 = t2 + ElapsedWidth'(cfg.refill_time_ms);
  assign t4 = t3 + ElapsedWidth'(drip_ticks_r);

  always_comb begin
    case (phase_r)
      PH_SQUIRT: thresh = t1;
      PH_SETTLE: thresh = t2;
      PH_SUCK:   thresh = t3;
      default:   thresh = t4;
    endcase
  end

  assign phase_done = (elapsed_inc >= thresh);

  // Next phase.
  always_comb begin
    phase_nxt = phase_r;
    unique case (action)
      ACT_TICK: begin
        if (busy && phase_done) begin
          unique case (phase_r)
            PH_SQUIRT: phase_nxt = PH_SETTLE;
            PH_SETTLE: phase_nxt = PH_SUCK;
            PH_SUCK:   phase_nxt = PH_DRIP;
            default:   phase_nxt = PH_READY;
          endcase
        end
      end
      ACT_DISPENSE: if (!busy) phase_nxt = PH_SQUIRT;
      ACT_STOP:     phase_nxt = PH_READY;
      default: ;
    endcase
  end

  // Counter, latched dispense values and drive levels.
  always_comb begin
    elapsed_nxt      = elapsed_r;
    squirt_ticks_nxt = squirt_ticks_r;
    drip_ticks_nxt   = drip_ticks_r;
    squirt_lvl_nxt   = squirt_lvl_r;
    suck_lvl_nxt     = suck_lvl_r;
    if (is_tick && busy) begin
      elapsed_nxt = elapsed_inc;
      if (phase_done) begin
        unique case (phase_r)
          PH_SQUIRT: begin
            squirt_lvl_nxt = '0;
            suck_lvl_nxt   = '0;
          end
          PH_SETTLE: begin
            squirt_lvl_nxt = '0;
            suck_lvl_nxt   = cfg.drive_level;
          end
          PH_SUCK: begin
            squirt_lvl_nxt = '0;
            suck_lvl_nxt   = '0;
          end
          default: ;
        endcase
      end
    end else if (start) begin
      elapsed_nxt      = '0;
      squirt_ticks_nxt = {1'b0, quantity} + {2'b00, quantity[TimeWidth-1:1]};
      drip_ticks_nxt   = (quantity == SHORT_DRIP_QTY) ? cfg.short_drip_ms
                                                      : cfg.drip_wait_ms;
      squirt_lvl_nxt   = cfg.drive_level;
      suck_lvl_nxt     = '0;
    end else if (is_stop) begin
      squirt_lvl_nxt = '0;
      suck_lvl_nxt   = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r        <= PH_READY;
      elapsed_r      <= '0;
      squirt_ticks_r <= '0;
      drip_ticks_r   <= '0;
      squirt_lvl_r   <= '0;
      suck_lvl_r     <= '0;
    end else if (fire) begin
      phase_r        <= phase_nxt;
      elapsed_r      <= elapsed_nxt;
      squirt_ticks_r <= squirt_ticks_nxt;
      drip_ticks_r   <= drip_ticks_nxt;
      squirt_lvl_r   <= squirt_lvl_nxt;
      suck_lvl_r     <= suck_lvl_nxt;
    end
  end

  always_comb begin
    res.accepted     = start;
    res.busy_res     = (phase_nxt != PH_READY);
    res.phase        = phase_nxt;
    res.squirt_drive = squirt_lvl_nxt;
    res.suck_drive   = suck_lvl_nxt;
  end

`ifndef NO_ASSERTIONS
  // The two pump directions are never driven at the same time.
  a_one_direction: assert property (@(posedge clk) disable iff (!rst_n)
    !((squirt_lvl_r != '0) && (suck_lvl_r != '0)))
    else $error("squirt and suck drives both active");

  // When ready, both drives are off.
  a_ready_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_READY) |-> ((squirt_lvl_r == '0) && (suck_lvl_r == '0)))
    else $error("drive active while ready");

  // A dispense request during a cycle leaves the cycle alone.
  a_busy_ignore: assert property (@(posedge clk) disable iff (!rst_n)
    (fire && is_dispense && busy) |=>
      ((phase_r == $past(phase_r)) && (elapsed_r == $past(elapsed_r))))
    else $error("dispense while busy disturbed the cycle");

  // A tick during a cycle never moves the counter backwards.
  a_elapsed_mono: assert property (@(posedge clk) disable iff (!rst_n)
    (fire && is_tick && busy) |=> (elapsed_r >= $past(elapsed_r)))
    else $error("elapsed counter went backwards");

  // A stop always ends at ready.
  a_stop_ready: assert property (@(posedge clk) disable iff (!rst_n)
    (fire && is_stop) |=> (phase_r == PH_READY))
    else $error("stop did not return to ready");
`endif

endmodule

// ===== rtl/timed_syringe_pump_sequencer.sv =====
// Channel  Dir  Handshake            Word
// in_ch    in   valid/ready          action[1:0], quantity[15:0]
// out_ch   out  valid/ready          accepted, busy_res, phase[2:0],
//                                    squirt_drive[7:0], suck_drive[7:0]
// cfg_*    in   cfg_we, no ready     cfg_idx[2:0], cfg_wdata[15:0]
//
// Every accepted word updates the sequencer state and its result appears
// on out_ch in the next cycle; one word per cycle is sustained while out_ch
// is ready. The single result register sets the latency; in_ch stalls only
// while that register holds a word that out_ch has not taken.
// Reset is synchronous and active low; configuration returns to its defaults.
module timed_syringe_pump_sequencer
  import tssp_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst_n,
  tssp_in_if.sink                 in_ch,
  tssp_out_if.source              out_ch,
  input  logic                    cfg_we,
  input  logic [CfgIdxWidth-1:0]  cfg_idx,
  input  logic [CfgDataWidth-1:0] cfg_wdata
);

  cfg_t cfg;
  res_t res;
  res_t out_res_r;
  logic out_valid_r;
  logic in_fire;

  assign in_ch.ready = !out_valid_r || out_ch.ready;
  assign in_fire     = in_ch.valid && in_ch.ready;

  tssp_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  tssp_core u_core (
    .clk      (clk),
    .rst_n    (rst_n),
    .fire     (in_fire),
    .action   (in_ch.action),
    .quantity (in_ch.quantity),
    .cfg      (cfg),
    .res      (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_ch.ready) begin
      out_valid_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      out_res_r <= res;
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.accepted     = out_res_r.accepted;
  assign out_ch.busy_res     = out_res_r.busy_res;
  assign out_ch.phase        = out_res_r.phase;
  assign out_ch.squirt_drive = out_res_r.squirt_drive;
  assign out_ch.suck_drive   = out_res_r.suck_drive;

endmodule
